// ===== rtl/gpsl_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package gpsl_pkg;

  localparam int CHANNELS   = 4;
  localparam int ANGLE_BITS = 16;

  // port field widths
  localparam int OP_W    = 2;
  localparam int CHAN_W  = 3;
  localparam int FIELD_W = 16;
  localparam int POS_W   = 17;
  localparam int ADDR_W  = 5;
  localparam int DATA_W  = 32;
  localparam int NUM_ZERO = 4;
  localparam int MASK_W  = 4;

  localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int OUT_BITS = ANGLE_BITS + 1;
  // room for a 17-bit sum plus a sign bit
  localparam int ALU_W    = ((ANGLE_BITS > FIELD_W) ? ANGLE_BITS : FIELD_W) + 2;

  localparam logic [CHAN_W:0] CH_LIMIT = (CHAN_W + 1)'(CHANNELS);

  typedef enum logic [OP_W-1:0] {
    OP_SET  = 2'd0,
    OP_READ = 2'd1,
    OP_TICK = 2'd2,
    OP_INIT = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    REG_ZERO0   = 3'd0,
    REG_ZERO1   = 3'd1,
    REG_ZERO2   = 3'd2,
    REG_ZERO3   = 3'd3,
    REG_CW_MASK = 3'd4,
    REG_STEP    = 3'd5,
    REG_MAX     = 3'd6
  } reg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CMP,
    S_STEP,
    S_OUT,
    S_WRAP,
    S_DONE
  } state_t;

  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } alu_op_t;

  typedef struct packed {
    logic [NUM_ZERO-1:0][FIELD_W-1:0] zero;
    logic [MASK_W-1:0]                cw_mask;
    logic [FIELD_W-1:0]               step;
    logic [FIELD_W-1:0]               max_angle;
  } cfg_t;

  typedef struct packed {
    alu_op_t          op;
    logic [ALU_W-1:0] a;
    logic [ALU_W-1:0] b;
    logic [ALU_W-1:0] c;
  } alu_req_t;

  typedef struct packed {
    logic [ALU_W-1:0] sum;
    logic             lt;
    logic             gt;
    logic             neg;
    logic             zero;
  } alu_rsp_t;

  function automatic logic [ANGLE_BITS-1:0] ang_of(input logic [FIELD_W-1:0] v);
    return ANGLE_BITS'(v);
  endfunction

endpackage

`default_nettype wire

// ===== rtl/gpsl_cfg.sv =====
`timescale 1ns / 1ps
`default_nettype none

module gpsl_cfg (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [gpsl_pkg::ADDR_W-1:0] paddr,
  input  wire logic [gpsl_pkg::DATA_W-1:0] pwdata,
  output logic      [gpsl_pkg::DATA_W-1:0] prdata,
  output logic                             pready,
  output gpsl_pkg::cfg_t                   cfg
);
  import gpsl_pkg::*;

  cfg_t     cfg_r;
  logic     wr_en;
  reg_idx_t idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.zero      <= '0;
      cfg_r.cw_mask   <= MASK_W'(15);
      cfg_r.step      <= FIELD_W'(1);
      cfg_r.max_angle <= FIELD_W'(360);
    end else if (wr_en) begin
      unique case (idx)
        REG_ZERO0:   cfg_r.zero[0]   <= pwdata[FIELD_W-1:0];
        REG_ZERO1:   cfg_r.zero[1]   <= pwdata[FIELD_W-1:0];
        REG_ZERO2:   cfg_r.zero[2]   <= pwdata[FIELD_W-1:0];
        REG_ZERO3:   cfg_r.zero[3]   <= pwdata[FIELD_W-1:0];
        REG_CW_MASK: cfg_r.cw_mask   <= pwdata[MASK_W-1:0];
        REG_STEP:    cfg_r.step      <= pwdata[FIELD_W-1:0];
        REG_MAX:     cfg_r.max_angle <= pwdata[FIELD_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_ZERO0:   prdata = DATA_W'(cfg_r.zero[0]);
      REG_ZERO1:   prdata = DATA_W'(cfg_r.zero[1]);
      REG_ZERO2:   prdata = DATA_W'(cfg_r.zero[2]);
      REG_ZERO3:   prdata = DATA_W'(cfg_r.zero[3]);
      REG_CW_MASK: prdata = DATA_W'(cfg_r.cw_mask);
      REG_STEP:    prdata = DATA_W'(cfg_r.step);
      REG_MAX:     prdata = DATA_W'(cfg_r.max_angle);
      default:     prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/gpsl_alu.sv =====
`timescale 1ns / 1ps
`default_nettype none

// shared add/subtract followed by an unsigned compare against c
module gpsl_alu (
  input  wire gpsl_pkg::alu_req_t req,
  output gpsl_pkg::alu_rsp_t      rsp
);
  import gpsl_pkg::*;

  logic [ALU_W-1:0] sum;

  assign sum      = (req.op == ALU_ADD) ? (req.a + req.b) : (req.a - req.b);
  assign rsp.sum  = sum;
  assign rsp.lt   = sum < req.c;
  assign rsp.gt   = sum > req.c;
  assign rsp.neg  = sum[ALU_W-1];
  assign rsp.zero = (sum == '0);

endmodule

`default_nettype wire

// ===== rtl/gpsl_seq.sv =====
`timescale 1ns / 1ps
`default_nettype none

module gpsl_seq (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire gpsl_pkg::cfg_t               cfg,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire gpsl_pkg::op_t                in_op,
  input  wire logic [gpsl_pkg::CHAN_W-1:0]  in_channel,
  input  wire logic [gpsl_pkg::FIELD_W-1:0] in_angle,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic                              out_ok,
  output logic      [gpsl_pkg::POS_W-1:0]   out_pos,
  output gpsl_pkg::alu_req_t                alu_req,
  input  wire gpsl_pkg::alu_rsp_t           alu_rsp
);
  import gpsl_pkg::*;

  state_t                state_r, state_nxt;
  logic [CH_IDX_W-1:0]   ch_r;
  logic [ANGLE_BITS-1:0] cmd_r  [CHANNELS];
  logic [ANGLE_BITS-1:0] ramp_r [CHANNELS];
  logic [OUT_BITS-1:0]   pos_r  [CHANNELS];
  logic                  down_r;
  logic [ALU_W-1:0]      diff_r;
  logic                  out_valid_r, out_ok_r;
  logic [POS_W-1:0]      out_pos_r;

  logic [CH_IDX_W-1:0]   idx;
  logic [ANGLE_BITS-1:0] cur_cmd, cur_ramp, cur_zero;
  logic                  cur_cw;
  logic                  ch_ok, angle_ok, slot_free, accept, last_ch;
  logic                  move, wr_ramp, wr_pos, ld_diff;
  logic [ANGLE_BITS-1:0] ramp_val;
  logic [OUT_BITS-1:0]   pos_val;
  logic                  res_ok;
  logic [POS_W-1:0]      res_pos;

  assign idx       = (state_r == S_IDLE) ? in_channel[CH_IDX_W-1:0] : ch_r;
  assign cur_cmd   = cmd_r[idx];
  assign cur_ramp  = ramp_r[idx];
  assign cur_zero  = ang_of(cfg.zero[idx]);
  assign cur_cw    = cfg.cw_mask[idx];
  assign ch_ok     = {1'b0, in_channel} < CH_LIMIT;
  assign angle_ok  = in_angle <= cfg.max_angle;
  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE) && slot_free;
  assign accept    = in_valid && in_ready;
  assign last_ch   = (ch_r == CH_IDX_W'(CHANNELS - 1));

  assign out_valid = out_valid_r;
  assign out_ok    = out_ok_r;
  assign out_pos   = out_pos_r;

  // datapath control per step
  always_comb begin
    alu_req  = '{op: ALU_ADD, a: '0, b: '0, c: '0};
    move     = 1'b0;
    wr_ramp  = 1'b0;
    wr_pos   = 1'b0;
    ld_diff  = 1'b0;
    ramp_val = cur_cmd;
    pos_val  = alu_rsp.sum[OUT_BITS-1:0];
    unique case (state_r)
      S_CMP: begin
        alu_req = '{op: ALU_SUB, a: ALU_W'(cur_cmd), b: ALU_W'(cur_ramp), c: '0};
      end
      S_STEP: begin
        if (down_r) begin
          // cmd + step < ramp  <=>  ramp - step stays positive and exceeds cmd
          alu_req = '{op: ALU_SUB, a: ALU_W'(cur_ramp), b: ALU_W'(cfg.step),
                      c: ALU_W'(cur_cmd)};
          move    = !alu_rsp.neg && alu_rsp.gt;
        end else begin
          alu_req = '{op: ALU_ADD, a: ALU_W'(cur_ramp), b: ALU_W'(cfg.step),
                      c: ALU_W'(cur_cmd)};
          move    = alu_rsp.lt;
        end
        wr_ramp  = 1'b1;
        ramp_val = move ? alu_rsp.sum[ANGLE_BITS-1:0] : cur_cmd;
      end
      S_OUT: begin
        if (cur_cw) begin
          alu_req = '{op: ALU_ADD, a: ALU_W'(cur_zero), b: ALU_W'(cur_ramp), c: '0};
          wr_pos  = 1'b1;
        end else begin
          alu_req = '{op: ALU_SUB, a: ALU_W'(cur_zero), b: ALU_W'(cur_ramp), c: '0};
          wr_pos  = !alu_rsp.neg;
          ld_diff = alu_rsp.neg;
        end
      end
      S_WRAP: begin
        alu_req = '{op: ALU_ADD, a: ALU_W'(cfg.max_angle), b: diff_r, c: '0};
        wr_pos  = 1'b1;
      end
      default: ;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (accept && in_op == OP_TICK) state_nxt = S_CMP;
      S_CMP: begin
        if (!alu_rsp.zero)  state_nxt = S_STEP;
        else if (last_ch)   state_nxt = S_DONE;
      end
      S_STEP: state_nxt = S_OUT;
      S_OUT: begin
        if (ld_diff)      state_nxt = S_WRAP;
        else if (last_ch) state_nxt = S_DONE;
        else              state_nxt = S_CMP;
      end
      S_WRAP: state_nxt = last_ch ? S_DONE : S_CMP;
      S_DONE: if (slot_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // immediate result for set, read and init
  always_comb begin
    res_ok  = 1'b1;
    res_pos = '0;
    unique case (in_op)
      OP_SET:  res_ok = ch_ok && angle_ok;
      OP_READ: begin
        res_ok  = ch_ok;
        res_pos = ch_ok ? POS_W'(pos_r[idx]) : '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ch_r    <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_IDLE)
        ch_r <= '0;
      else if (state_nxt == S_CMP)
        ch_r <= ch_r + CH_IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CHANNELS; i++) begin
        cmd_r[i]  <= '0;
        ramp_r[i] <= '0;
        pos_r[i]  <= '0;
      end
    end else begin
      if (accept && in_op == OP_SET && ch_ok && angle_ok)
        cmd_r[idx] <= ANGLE_BITS'(in_angle);
      if (accept && in_op == OP_INIT) begin
        for (int i = 0; i < CHANNELS; i++) begin
          cmd_r[i]  <= ang_of(cfg.zero[i]);
          ramp_r[i] <= ang_of(cfg.zero[i]);
          pos_r[i]  <= OUT_BITS'(ang_of(cfg.zero[i]));
        end
      end
      if (wr_ramp) ramp_r[idx] <= ramp_val;
      if (wr_pos)  pos_r[idx]  <= pos_val;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_CMP) down_r <= alu_rsp.neg;
    if (ld_diff)          diff_r <= alu_rsp.sum;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept && in_op != OP_TICK) begin
      out_valid_r <= 1'b1;
    end else if (state_r == S_DONE && slot_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && in_op != OP_TICK) begin
      out_ok_r  <= res_ok;
      out_pos_r <= res_pos;
    end else if (state_r == S_DONE && slot_free) begin
      out_ok_r  <= 1'b1;
      out_pos_r <= '0;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/gauge_pointer_slew_limiter_top.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Set, read and init: result beat in the cycle after the input beat, one item per cycle
// while the output is taken and no tick runs. Tick: channels are walked in turn through
// one shared add/compare unit; a channel whose ramp sits on the command is only compared,
// others step and update their position; a negative counter-clockwise output wraps.
// Reset (synchronous, rst_n low) clears command, ramp and position of every channel
// and loads the registers with zeros 0, clockwise mask 15, step 1, max angle 360.
module gauge_pointer_slew_limiter_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [23:0] in_tdata,   // channel[2:0], angle[18:3], zero pad
  input  wire logic [1:0]  in_tuser,   // op[1:0]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [23:0] out_tdata,  // position[16:0], zero pad
  output logic      [0:0]  out_tuser,  // ok[0]
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [4:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic      [31:0] cfg_prdata,
  output logic             cfg_pready
);
  import gpsl_pkg::*;

  cfg_t             cfg;
  alu_req_t         alu_req;
  alu_rsp_t         alu_rsp;
  logic             out_ok;
  logic [POS_W-1:0] out_pos;

  gpsl_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  gpsl_alu u_alu (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  gpsl_seq u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_op      (op_t'(in_tuser)),
    .in_channel (in_tdata[CHAN_W-1:0]),
    .in_angle   (in_tdata[CHAN_W+FIELD_W-1:CHAN_W]),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_ok     (out_ok),
    .out_pos    (out_pos),
    .alu_req    (alu_req),
    .alu_rsp    (alu_rsp)
  );

  assign out_tdata = 24'(out_pos);
  assign out_tuser = out_ok;

endmodule

`default_nettype wire
